// ----- rtl/etl_pkg.sv -----
`timescale 1ns / 1ps

package etl_pkg;

    localparam int CHAR_BITS      = 16;
    localparam int NAME_BUF_CHARS = 8;
    localparam int NAME_IDX_BITS  = $clog2(NAME_BUF_CHARS);
    // length saturates at NAME_BUF_CHARS + 1
    localparam int NAME_LEN_BITS  = $clog2(NAME_BUF_CHARS + 2);
    localparam int TOK_BITS       = 5;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_STR,
        MODE_ESC,
        MODE_ERROR
    } t_mode;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_GT,
        PEND_LT,
        PEND_BANG
    } t_pend;

    typedef enum logic [1:0] {
        KIND_VALUE,
        KIND_TOKEN,
        KIND_ERROR
    } t_kind;

    localparam logic [1:0] ERR_ILLEGAL_CHAR = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    localparam logic [TOK_BITS-1:0] TOK_END       = 5'd0;
    localparam logic [TOK_BITS-1:0] TOK_ID        = 5'd1;
    localparam logic [TOK_BITS-1:0] TOK_NUMBER    = 5'd2;
    localparam logic [TOK_BITS-1:0] TOK_STRING    = 5'd3;
    localparam logic [TOK_BITS-1:0] TOK_WORD_BASE = 5'd4;
    localparam logic [TOK_BITS-1:0] TOK_LPAREN    = 5'd14;
    localparam logic [TOK_BITS-1:0] TOK_RPAREN    = 5'd15;
    localparam logic [TOK_BITS-1:0] TOK_COMMA     = 5'd16;
    localparam logic [TOK_BITS-1:0] TOK_PLUS      = 5'd17;
    localparam logic [TOK_BITS-1:0] TOK_MINUS     = 5'd18;
    localparam logic [TOK_BITS-1:0] TOK_STAR      = 5'd19;
    localparam logic [TOK_BITS-1:0] TOK_SLASH     = 5'd20;
    localparam logic [TOK_BITS-1:0] TOK_AMP       = 5'd21;
    localparam logic [TOK_BITS-1:0] TOK_EQ        = 5'd22;
    localparam logic [TOK_BITS-1:0] TOK_GE        = 5'd23;
    localparam logic [TOK_BITS-1:0] TOK_GT        = 5'd24;
    localparam logic [TOK_BITS-1:0] TOK_NE        = 5'd25;
    localparam logic [TOK_BITS-1:0] TOK_LE        = 5'd26;
    localparam logic [TOK_BITS-1:0] TOK_LT        = 5'd27;

    localparam logic [CHAR_BITS-1:0] CH_TAB    = CHAR_BITS'(8'h09);
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = CHAR_BITS'(" ");
    localparam logic [CHAR_BITS-1:0] CH_BANG   = CHAR_BITS'("!");
    localparam logic [CHAR_BITS-1:0] CH_DQUOTE = CHAR_BITS'(8'h22);
    localparam logic [CHAR_BITS-1:0] CH_DOLLAR = CHAR_BITS'("$");
    localparam logic [CHAR_BITS-1:0] CH_AMP    = CHAR_BITS'("&");
    localparam logic [CHAR_BITS-1:0] CH_SQUOTE = CHAR_BITS'(8'h27);
    localparam logic [CHAR_BITS-1:0] CH_LPAREN = CHAR_BITS'("(");
    localparam logic [CHAR_BITS-1:0] CH_RPAREN = CHAR_BITS'(")");
    localparam logic [CHAR_BITS-1:0] CH_STAR   = CHAR_BITS'("*");
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = CHAR_BITS'("+");
    localparam logic [CHAR_BITS-1:0] CH_COMMA  = CHAR_BITS'(",");
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = CHAR_BITS'("-");
    localparam logic [CHAR_BITS-1:0] CH_DOT    = CHAR_BITS'(".");
    localparam logic [CHAR_BITS-1:0] CH_SLASH  = CHAR_BITS'("/");
    localparam logic [CHAR_BITS-1:0] CH_DIG0   = CHAR_BITS'("0");
    localparam logic [CHAR_BITS-1:0] CH_DIG9   = CHAR_BITS'("9");
    localparam logic [CHAR_BITS-1:0] CH_SEMI   = CHAR_BITS'(";");
    localparam logic [CHAR_BITS-1:0] CH_LESS   = CHAR_BITS'("<");
    localparam logic [CHAR_BITS-1:0] CH_EQUAL  = CHAR_BITS'("=");
    localparam logic [CHAR_BITS-1:0] CH_MORE   = CHAR_BITS'(">");
    localparam logic [CHAR_BITS-1:0] CH_UPPA   = CHAR_BITS'("A");
    localparam logic [CHAR_BITS-1:0] CH_UPPZ   = CHAR_BITS'("Z");
    localparam logic [CHAR_BITS-1:0] CH_LBRACK = CHAR_BITS'("[");
    localparam logic [CHAR_BITS-1:0] CH_BSLASH = CHAR_BITS'(8'h5C);
    localparam logic [CHAR_BITS-1:0] CH_RBRACK = CHAR_BITS'("]");
    localparam logic [CHAR_BITS-1:0] CH_CASE   = CHAR_BITS'(8'h20);

    // reserved words, right-aligned ascii, last char in the low byte
    localparam int RES_COUNT = 10;
    localparam logic [8*NAME_BUF_CHARS-1:0] RES_WORDS [RES_COUNT] = '{
        "false", "true", "infinity", "nan", "defined",
        "div", "mod", "and", "or", "not"
    };
    localparam int RES_LEN [RES_COUNT] = '{5, 4, 8, 3, 7, 3, 3, 3, 2, 3};

    typedef struct packed {
        t_kind                 kind;
        logic [TOK_BITS-1:0]   tok;
        logic [CHAR_BITS-1:0]  vc;
        logic [1:0]            err;
        logic                  last;
    } t_result;

    typedef struct packed {
        t_mode                    mode;
        logic                     quote_single;
        t_pend                    pend;
        logic [NAME_LEN_BITS-1:0] name_len;
    } t_lex_state;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef logic [NAME_BUF_CHARS-1:0][CHAR_BITS-1:0] t_name_buf;

    function automatic logic [7:0] res_char(input int w, input int i);
        logic [8*NAME_BUF_CHARS-1:0] word;
        word = RES_WORDS[w] >> (8 * (RES_LEN[w] - 1 - i));
        return word[7:0];
    endfunction

endpackage

// ----- rtl/etl_fifo.sv -----
`timescale 1ns / 1ps

module etl_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  etl_pkg::t_push                     i_push,
    input  logic                               i_pop,
    output etl_pkg::t_result                   o_head,
    output logic [etl_pkg::FIFO_CNT_BITS-1:0]  o_count
);

    etl_pkg::t_result                    r_mem [etl_pkg::FIFO_DEPTH];
    logic [etl_pkg::FIFO_PTR_BITS-1:0]   r_wr;
    logic [etl_pkg::FIFO_PTR_BITS-1:0]   r_rd;
    logic [etl_pkg::FIFO_CNT_BITS-1:0]   r_count;
    logic [etl_pkg::FIFO_PTR_BITS-1:0]   n_wr1;

    assign n_wr1   = r_wr + etl_pkg::FIFO_PTR_BITS'(1);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + etl_pkg::FIFO_PTR_BITS'(i_push.cnt);
            r_rd    <= r_rd + etl_pkg::FIFO_PTR_BITS'(i_pop);
            r_count <= r_count + etl_pkg::FIFO_CNT_BITS'(i_push.cnt)
                       - etl_pkg::FIFO_CNT_BITS'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[n_wr1] <= i_push.r1;
        end
    end

endmodule

// ----- rtl/etl_step.sv -----
`timescale 1ns / 1ps

module etl_step (
    input  etl_pkg::t_lex_state                i_state,
    input  etl_pkg::t_name_buf                 i_name_buf,
    input  logic [etl_pkg::CHAR_BITS-1:0]      i_ch,
    input  logic                               i_eoi,
    output etl_pkg::t_lex_state                o_state,
    output logic                               o_buf_we,
    output logic [etl_pkg::NAME_IDX_BITS-1:0]  o_buf_idx,
    output etl_pkg::t_push                     o_push
);

    typedef struct packed {
        logic               emit;
        etl_pkg::t_result   res;
        etl_pkg::t_mode     mode;
        etl_pkg::t_pend     pend;
        logic               quote_single;
        logic               ident;
    } t_start;

    function automatic etl_pkg::t_result mk_value(input logic [etl_pkg::CHAR_BITS-1:0] c);
        etl_pkg::t_result r;
        r      = '0;
        r.kind = etl_pkg::KIND_VALUE;
        r.vc   = c;
        return r;
    endfunction

    function automatic etl_pkg::t_result mk_token(input logic [etl_pkg::TOK_BITS-1:0] t);
        etl_pkg::t_result r;
        r      = '0;
        r.kind = etl_pkg::KIND_TOKEN;
        r.tok  = t;
        return r;
    endfunction

    function automatic etl_pkg::t_result mk_error(input logic [1:0] e);
        etl_pkg::t_result r;
        r      = '0;
        r.kind = etl_pkg::KIND_ERROR;
        r.err  = e;
        return r;
    endfunction

    function automatic logic is_space(input logic [etl_pkg::CHAR_BITS-1:0] c);
        return (c == etl_pkg::CH_SPACE) || (c == etl_pkg::CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [etl_pkg::CHAR_BITS-1:0] c);
        return c inside {[etl_pkg::CH_DIG0 : etl_pkg::CH_DIG9]};
    endfunction

    function automatic logic is_name_char(input logic [etl_pkg::CHAR_BITS-1:0] c);
        return !(c inside {etl_pkg::CH_SPACE, etl_pkg::CH_TAB, etl_pkg::CH_BANG,
                           etl_pkg::CH_DOLLAR, etl_pkg::CH_AMP, etl_pkg::CH_STAR,
                           etl_pkg::CH_LPAREN, etl_pkg::CH_RPAREN, etl_pkg::CH_MINUS,
                           etl_pkg::CH_PLUS, etl_pkg::CH_EQUAL, etl_pkg::CH_LBRACK,
                           etl_pkg::CH_RBRACK, etl_pkg::CH_SEMI, etl_pkg::CH_DQUOTE,
                           etl_pkg::CH_SQUOTE, etl_pkg::CH_LESS, etl_pkg::CH_MORE,
                           etl_pkg::CH_COMMA, etl_pkg::CH_SLASH});
    endfunction

    function automatic logic [etl_pkg::CHAR_BITS-1:0] to_lower(
        input logic [etl_pkg::CHAR_BITS-1:0] c);
        if (c inside {[etl_pkg::CH_UPPA : etl_pkg::CH_UPPZ]}) begin
            return c + etl_pkg::CH_CASE;
        end
        return c;
    endfunction

    // first character of a token, from idle with nothing pending
    function automatic t_start start_char(input logic [etl_pkg::CHAR_BITS-1:0] c);
        t_start s;
        s              = '0;
        s.mode         = etl_pkg::MODE_IDLE;
        s.pend         = etl_pkg::PEND_NONE;
        if (is_space(c)) begin
            s.emit = 1'b0;
        end else if (is_digit(c)) begin
            s.mode = etl_pkg::MODE_INT;
            s.emit = 1'b1;
            s.res  = mk_value(c);
        end else if (is_name_char(c)) begin
            s.mode  = etl_pkg::MODE_IDENT;
            s.ident = 1'b1;
            s.emit  = 1'b1;
            s.res   = mk_value(c);
        end else begin
            s.emit = 1'b1;
            case (c)
                etl_pkg::CH_DQUOTE: begin
                    s.mode = etl_pkg::MODE_STR;
                    s.emit = 1'b0;
                end
                etl_pkg::CH_SQUOTE: begin
                    s.mode         = etl_pkg::MODE_STR;
                    s.quote_single = 1'b1;
                    s.emit         = 1'b0;
                end
                etl_pkg::CH_MORE: begin
                    s.pend = etl_pkg::PEND_GT;
                    s.emit = 1'b0;
                end
                etl_pkg::CH_LESS: begin
                    s.pend = etl_pkg::PEND_LT;
                    s.emit = 1'b0;
                end
                etl_pkg::CH_BANG: begin
                    s.pend = etl_pkg::PEND_BANG;
                    s.emit = 1'b0;
                end
                etl_pkg::CH_LPAREN: s.res = mk_token(etl_pkg::TOK_LPAREN);
                etl_pkg::CH_RPAREN: s.res = mk_token(etl_pkg::TOK_RPAREN);
                etl_pkg::CH_COMMA:  s.res = mk_token(etl_pkg::TOK_COMMA);
                etl_pkg::CH_PLUS:   s.res = mk_token(etl_pkg::TOK_PLUS);
                etl_pkg::CH_MINUS:  s.res = mk_token(etl_pkg::TOK_MINUS);
                etl_pkg::CH_STAR:   s.res = mk_token(etl_pkg::TOK_STAR);
                etl_pkg::CH_SLASH:  s.res = mk_token(etl_pkg::TOK_SLASH);
                etl_pkg::CH_AMP:    s.res = mk_token(etl_pkg::TOK_AMP);
                etl_pkg::CH_EQUAL:  s.res = mk_token(etl_pkg::TOK_EQ);
                default: begin
                    s.mode = etl_pkg::MODE_ERROR;
                    s.res  = mk_error(etl_pkg::ERR_ILLEGAL_CHAR);
                end
            endcase
        end
        return s;
    endfunction

    logic [etl_pkg::TOK_BITS-1:0] ident_tok;
    logic                         word_hit;
    t_start                       sc;
    logic                         use_start;
    logic                         a_v;
    etl_pkg::t_result             a_res;
    logic                         b_v;
    etl_pkg::t_result             b_res;
    etl_pkg::t_lex_state          base_state;
    logic [etl_pkg::CHAR_BITS-1:0] quote_ch;

    // reserved word match: length compare plus per-position compares in parallel;
    // a saturated length never equals a word length
    always_comb begin
        ident_tok = etl_pkg::TOK_ID;
        word_hit  = 1'b0;
        for (int w = etl_pkg::RES_COUNT - 1; w >= 0; w--) begin
            word_hit = (i_state.name_len == etl_pkg::NAME_LEN_BITS'(etl_pkg::RES_LEN[w]));
            for (int i = 0; i < etl_pkg::NAME_BUF_CHARS; i++) begin
                if (i < etl_pkg::RES_LEN[w] &&
                    to_lower(i_name_buf[i]) !=
                    etl_pkg::CHAR_BITS'(etl_pkg::res_char(w, i))) begin
                    word_hit = 1'b0;
                end
            end
            if (word_hit) begin
                ident_tok = etl_pkg::TOK_WORD_BASE + etl_pkg::TOK_BITS'(w);
            end
        end
    end

    assign sc       = start_char(i_ch);
    assign quote_ch = i_state.quote_single ? etl_pkg::CH_SQUOTE : etl_pkg::CH_DQUOTE;

    always_comb begin
        base_state              = '0;
        base_state.mode         = etl_pkg::MODE_IDLE;
        base_state.pend         = etl_pkg::PEND_NONE;

        o_state   = i_state;
        o_buf_we  = 1'b0;
        o_buf_idx = '0;
        use_start = 1'b0;
        a_v       = 1'b0;
        a_res     = '0;
        b_v       = 1'b0;
        b_res     = '0;

        if (i_eoi) begin
            o_state = base_state;
            case (i_state.mode)
                etl_pkg::MODE_ERROR: begin
                    a_v = 1'b0;
                end
                etl_pkg::MODE_STR: begin
                    a_v   = 1'b1;
                    a_res = mk_error(etl_pkg::ERR_UNTERMINATED);
                end
                etl_pkg::MODE_ESC: begin
                    a_v   = 1'b1;
                    a_res = mk_error(etl_pkg::ERR_BAD_ESCAPE);
                end
                etl_pkg::MODE_IDENT, etl_pkg::MODE_INT, etl_pkg::MODE_FRAC: begin
                    a_v   = 1'b1;
                    a_res = mk_token((i_state.mode == etl_pkg::MODE_IDENT) ?
                                     ident_tok : etl_pkg::TOK_NUMBER);
                    b_v   = 1'b1;
                    b_res = mk_token(etl_pkg::TOK_END);
                end
                default: begin
                    case (i_state.pend)
                        etl_pkg::PEND_BANG: begin
                            a_v   = 1'b1;
                            a_res = mk_error(etl_pkg::ERR_ILLEGAL_CHAR);
                        end
                        etl_pkg::PEND_GT: begin
                            a_v   = 1'b1;
                            a_res = mk_token(etl_pkg::TOK_GT);
                            b_v   = 1'b1;
                            b_res = mk_token(etl_pkg::TOK_END);
                        end
                        etl_pkg::PEND_LT: begin
                            a_v   = 1'b1;
                            a_res = mk_token(etl_pkg::TOK_LT);
                            b_v   = 1'b1;
                            b_res = mk_token(etl_pkg::TOK_END);
                        end
                        default: begin
                            a_v   = 1'b1;
                            a_res = mk_token(etl_pkg::TOK_END);
                        end
                    endcase
                end
            endcase
        end else begin
            case (i_state.mode)
                etl_pkg::MODE_ERROR: begin
                    a_v = 1'b0;
                end
                etl_pkg::MODE_IDENT: begin
                    if (is_name_char(i_ch)) begin
                        if (i_state.name_len < etl_pkg::NAME_LEN_BITS'(etl_pkg::NAME_BUF_CHARS)) begin
                            o_buf_we  = 1'b1;
                            o_buf_idx = i_state.name_len[etl_pkg::NAME_IDX_BITS-1:0];
                        end
                        if (i_state.name_len <= etl_pkg::NAME_LEN_BITS'(etl_pkg::NAME_BUF_CHARS)) begin
                            o_state.name_len = i_state.name_len + etl_pkg::NAME_LEN_BITS'(1);
                        end
                        a_v   = 1'b1;
                        a_res = mk_value(i_ch);
                    end else begin
                        a_v       = 1'b1;
                        a_res     = mk_token(ident_tok);
                        use_start = 1'b1;
                    end
                end
                etl_pkg::MODE_INT, etl_pkg::MODE_FRAC: begin
                    if (is_digit(i_ch)) begin
                        a_v   = 1'b1;
                        a_res = mk_value(i_ch);
                    end else if (i_ch == etl_pkg::CH_DOT &&
                                 i_state.mode == etl_pkg::MODE_INT) begin
                        o_state.mode = etl_pkg::MODE_FRAC;
                        a_v          = 1'b1;
                        a_res        = mk_value(i_ch);
                    end else begin
                        a_v       = 1'b1;
                        a_res     = mk_token(etl_pkg::TOK_NUMBER);
                        use_start = 1'b1;
                    end
                end
                etl_pkg::MODE_STR: begin
                    if (i_ch == quote_ch) begin
                        o_state.mode         = etl_pkg::MODE_IDLE;
                        o_state.quote_single = 1'b0;
                        a_v                  = 1'b1;
                        a_res                = mk_token(etl_pkg::TOK_STRING);
                    end else if (i_ch == etl_pkg::CH_BSLASH) begin
                        o_state.mode = etl_pkg::MODE_ESC;
                    end else begin
                        a_v   = 1'b1;
                        a_res = mk_value(i_ch);
                    end
                end
                etl_pkg::MODE_ESC: begin
                    a_v = 1'b1;
                    if (i_ch == etl_pkg::CH_BSLASH || i_ch == etl_pkg::CH_DQUOTE ||
                        i_ch == etl_pkg::CH_SQUOTE) begin
                        o_state.mode = etl_pkg::MODE_STR;
                        a_res        = mk_value(i_ch);
                    end else begin
                        o_state.mode = etl_pkg::MODE_ERROR;
                        a_res        = mk_error(etl_pkg::ERR_BAD_ESCAPE);
                    end
                end
                default: begin
                    o_state.pend = etl_pkg::PEND_NONE;
                    case (i_state.pend)
                        etl_pkg::PEND_GT: begin
                            a_v = 1'b1;
                            if (i_ch == etl_pkg::CH_EQUAL) begin
                                a_res = mk_token(etl_pkg::TOK_GE);
                            end else begin
                                a_res     = mk_token(etl_pkg::TOK_GT);
                                use_start = 1'b1;
                            end
                        end
                        etl_pkg::PEND_LT: begin
                            a_v = 1'b1;
                            if (i_ch == etl_pkg::CH_MORE) begin
                                a_res = mk_token(etl_pkg::TOK_NE);
                            end else if (i_ch == etl_pkg::CH_EQUAL) begin
                                a_res = mk_token(etl_pkg::TOK_LE);
                            end else begin
                                a_res     = mk_token(etl_pkg::TOK_LT);
                                use_start = 1'b1;
                            end
                        end
                        etl_pkg::PEND_BANG: begin
                            a_v = 1'b1;
                            if (i_ch == etl_pkg::CH_EQUAL) begin
                                a_res = mk_token(etl_pkg::TOK_NE);
                            end else begin
                                o_state.mode = etl_pkg::MODE_ERROR;
                                a_res        = mk_error(etl_pkg::ERR_ILLEGAL_CHAR);
                            end
                        end
                        default: begin
                            use_start = 1'b1;
                        end
                    endcase
                end
            endcase

            if (use_start) begin
                o_state.mode         = sc.mode;
                o_state.pend         = sc.pend;
                o_state.quote_single = sc.quote_single;
                o_state.name_len     = sc.ident ? etl_pkg::NAME_LEN_BITS'(1) : '0;
                if (sc.ident) begin
                    o_buf_we  = 1'b1;
                    o_buf_idx = '0;
                end
                b_v   = sc.emit;
                b_res = sc.res;
            end
        end
    end

    // pack the up to two results in order, marking the final one
    always_comb begin
        o_push = '0;
        if (a_v) begin
            o_push.r0      = a_res;
            o_push.r1      = b_res;
            o_push.cnt     = b_v ? 2'd2 : 2'd1;
            o_push.r0.last = !b_v;
            o_push.r1.last = b_v;
        end else begin
            o_push.r0      = b_res;
            o_push.cnt     = b_v ? 2'd1 : 2'd0;
            o_push.r0.last = b_v;
        end
    end

endmodule

// ----- rtl/expression_token_lexer_unit.sv -----
`timescale 1ns / 1ps
// with the result queue empty, the first result of a character is shown on the master side
//   in the cycle after the character is taken, and a second result once the first is taken
// throughput: one character per cycle unless the input stalls; a character that yields two
//   results sends them out in turn, and the 4-entry result queue absorbs the difference
// input stalls only while the result queue holds more than two results
// reset (synchronous, active low) returns the lexer to idle and empties the queue;
//   the name buffer is not cleared and is only read where it was written

module expression_token_lexer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input characters
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ch
    input  logic        s_axis_tlast,   // end_of_input
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [4:0] token_type, [20:5] value_char,
                                        // [22:21] error_code, [23] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
    output logic        m_axis_tlast    // last result of the character
);

    // lexer state: mode, quote kind, pending operator symbol, name length
    etl_pkg::t_lex_state                r_state;
    etl_pkg::t_lex_state                n_state;
    // identifier characters kept for reserved word matching
    etl_pkg::t_name_buf                 r_name_buf;

    logic                               in_accept;
    logic                               buf_we;
    logic [etl_pkg::NAME_IDX_BITS-1:0]  buf_idx;
    etl_pkg::t_push                     step_push;
    etl_pkg::t_push                     fifo_push;
    etl_pkg::t_result                   head;
    logic [etl_pkg::FIFO_CNT_BITS-1:0]  fifo_count;
    logic                               out_pop;

    // room for the worst case of two results from the next character
    assign s_axis_tready = (fifo_count <=
                            etl_pkg::FIFO_CNT_BITS'(etl_pkg::FIFO_DEPTH - 2));
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // whole transition for one character, short combinational path
    etl_step u_step (
        .i_state    (r_state),
        .i_name_buf (r_name_buf),
        .i_ch       (s_axis_tdata),
        .i_eoi      (s_axis_tlast),
        .o_state    (n_state),
        .o_buf_we   (buf_we),
        .o_buf_idx  (buf_idx),
        .o_push     (step_push)
    );

    // results only enter the queue for a taken request
    always_comb begin
        fifo_push = step_push;
        if (!in_accept) begin
            fifo_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: etl_pkg::MODE_IDLE, quote_single: 1'b0,
                         pend: etl_pkg::PEND_NONE, name_len: '0};
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // name buffer: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept && buf_we) begin
            r_name_buf[buf_idx] <= s_axis_tdata;
        end
    end

    // result queue doubles as the output register
    etl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_pop   (out_pop),
        .o_head  (head),
        .o_count (fifo_count)
    );

    assign m_axis_tvalid = (fifo_count != '0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {1'b0, head.err, head.vc, head.tok};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

// ----- rtl/etl_checker.sv -----
`timescale 1ns / 1ps

module etl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // value characters carry no token type and no error code
    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == etl_pkg::KIND_VALUE) |->
        (m_axis_tdata[4:0] == 5'd0 && m_axis_tdata[23:21] == 3'd0))
        else $error("value result with token or error bits");

    // errors carry no token type and no character
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == etl_pkg::KIND_ERROR) |->
        (m_axis_tdata[20:0] == 21'd0 && m_axis_tdata[23] == 1'b0))
        else $error("error result with token or character bits");

    // input only stalls while results are waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result queue");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind expression_token_lexer_unit etl_checker u_etl_checker (.*);
